### rtl/core/jpeg_dht_canonical_huffman_macros.svh
// assertion macros shared by the dht parser checkers
`ifndef JPEG_DHT_CANONICAL_HUFFMAN_MACROS_SVH
`define JPEG_DHT_CANONICAL_HUFFMAN_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define JDHT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define JDHT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/jdht_pkg.sv
// types and constants for the dht segment parser
`timescale 1ns / 1ps

package jdht_pkg;

  localparam int NUM_LENGTHS = 16;
  localparam int CODE_W      = 17;
  localparam logic [CODE_W-1:0] CODE_SAT = 17'h1FFFF;
  localparam logic [3:0]  LAST_COUNT = 4'd15;
  localparam logic [4:0]  MAX_LEN    = 5'd16;
  localparam logic [15:0] MIN_SEG_LEN = 16'd2;

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_CLASS   = 3'd2,
    PH_COUNTS  = 3'd3,
    PH_SYMBOLS = 3'd4
  } phase_t;

  typedef struct packed {
    logic        has_entry;
    logic [2:0]  table_num;
    logic [11:0] entry_index;
    logic [7:0]  symbol;
    logic [4:0]  code_length;
    logic [15:0] code;
    logic        code_overflow;
    logic        table_last;
    logic        segment_done;
    logic        segment_ok;
  } res_t;

  // handshake status between the output stage and the parser
  typedef struct packed {
    logic accept;
  } hs_t;

endpackage

### rtl/core/jdht_len_skip.sv
// skip over empty code lengths: next used length and the shifted code
`timescale 1ns / 1ps

module jdht_len_skip (
  input  logic [4:0]                   cur_len,
  input  logic [jdht_pkg::CODE_W-1:0]  cur_code,
  input  logic [15:0]                  nz_mask,
  output logic                         found,
  output logic [3:0]                   found_idx,
  output logic [4:0]                   new_len,
  output logic [jdht_pkg::CODE_W-1:0]  new_code
);
  import jdht_pkg::*;

  logic [15:0]         cand;
  logic [4:0]          shift_cnt;
  logic [2*CODE_W-1:0] wide;

  // only lengths above the current one are candidates
  always_comb begin
    cand = (cur_len[4]) ? 16'h0000 : (nz_mask & (16'hFFFF << cur_len[3:0]));
    found_idx = 4'd0;
    for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found_idx = 4'(i);
      end
    end
    found = |cand;
    new_len = found ? ({1'b0, found_idx} + 5'd1) : MAX_LEN;
    shift_cnt = new_len - cur_len;
    // one left shift per skipped length, saturating
    wide = {{CODE_W{1'b0}}, cur_code} << shift_cnt;
    new_code = (|wide[2*CODE_W-1:CODE_W]) ? CODE_SAT : wide[CODE_W-1:0];
  end

endmodule

### rtl/core/jdht_parser.sv
// segment state, count store and per-byte code generation
`timescale 1ns / 1ps

module jdht_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  jdht_pkg::hs_t  hs,
  input  logic [7:0]     seg_byte,
  output logic           res_valid,
  output jdht_pkg::res_t res
);
  import jdht_pkg::*;

  phase_t        phase_r, phase_nxt;
  logic [15:0]   seg_len_r, seg_len_nxt;
  logic [16:0]   bytes_r, bytes_nxt;
  logic [2:0]    table_r, table_nxt;
  logic [3:0]    cpos_r, cpos_nxt;
  logic [7:0]    counts_r [NUM_LENGTHS];
  logic [15:0]   nz_r;
  logic [11:0]   sum_r, sum_nxt;
  logic [4:0]    len_r, len_nxt;
  logic [7:0]    left_r, left_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [11:0]   sidx_r, sidx_nxt;
  logic [11:0]   sleft_r, sleft_nxt;

  logic          cnt_we;
  logic [16:0]   bytes_inc;
  logic [15:0]   chk_len;
  logic [16:0]   chk_bytes;
  logic [15:0]   chk_target;
  logic          bnd_done, bnd_ok;

  logic              skip_found;
  logic [3:0]        skip_idx;
  logic [4:0]        skip_len;
  logic [CODE_W-1:0] skip_code;
  logic              need_skip;
  logic [4:0]        eff_len;
  logic [CODE_W-1:0] eff_code;
  logic [7:0]        eff_left;
  logic [11:0]       sum_new;

  jdht_len_skip u_skip (
    .cur_len   (len_r),
    .cur_code  (code_r),
    .nz_mask   (nz_r),
    .found     (skip_found),
    .found_idx (skip_idx),
    .new_len   (skip_len),
    .new_code  (skip_code)
  );

  assign bytes_inc = bytes_r + 17'd1;
  assign sum_new   = sum_r + {4'd0, seg_byte};

  // segment end check, used after the length word and at each table boundary
  always_comb begin
    chk_len    = (phase_r == PH_LEN_LO) ? {seg_len_r[15:8], seg_byte} : seg_len_r;
    chk_bytes  = (phase_r == PH_LEN_LO) ? 17'd0 : bytes_inc;
    chk_target = chk_len - MIN_SEG_LEN;
    if (chk_len < MIN_SEG_LEN) begin
      bnd_done = 1'b1;
      bnd_ok   = 1'b0;
    end else begin
      bnd_done = chk_bytes >= {1'b0, chk_target};
      bnd_ok   = chk_bytes == {1'b0, chk_target};
    end
  end

  always_comb begin
    need_skip = (left_r == 8'd0) && (len_r < MAX_LEN);
    eff_len   = need_skip ? skip_len : len_r;
    eff_code  = need_skip ? skip_code : code_r;
    if (need_skip) begin
      eff_left = skip_found ? counts_r[skip_idx] : 8'd0;
    end else begin
      eff_left = left_r;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    seg_len_nxt = seg_len_r;
    bytes_nxt   = bytes_r;
    table_nxt   = table_r;
    cpos_nxt    = cpos_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    code_nxt    = code_r;
    sidx_nxt    = sidx_r;
    sleft_nxt   = sleft_r;
    cnt_we      = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    unique case (phase_r)
      PH_LEN_LO: begin
        seg_len_nxt = {seg_len_r[15:8], seg_byte};
        bytes_nxt   = 17'd0;
        if (bnd_done) begin
          res_valid        = 1'b1;
          res.segment_done = 1'b1;
          res.segment_ok   = bnd_ok;
          phase_nxt        = PH_LEN_HI;
        end else begin
          phase_nxt = PH_CLASS;
        end
      end
      PH_CLASS: begin
        bytes_nxt = bytes_inc;
        table_nxt = {seg_byte[4], seg_byte[1:0]};
        cpos_nxt  = 4'd0;
        sum_nxt   = 12'd0;
        phase_nxt = PH_COUNTS;
      end
      PH_COUNTS: begin
        bytes_nxt = bytes_inc;
        cnt_we    = 1'b1;
        sum_nxt   = sum_new;
        if (cpos_r != LAST_COUNT) begin
          cpos_nxt = cpos_r + 4'd1;
        end else begin
          sleft_nxt = sum_new;
          sidx_nxt  = 12'd0;
          code_nxt  = '0;
          len_nxt   = 5'd0;
          left_nxt  = 8'd0;
          if (sum_new == 12'd0) begin
            // empty table: no entries
            if (bnd_done) begin
              res_valid        = 1'b1;
              res.segment_done = 1'b1;
              res.segment_ok   = bnd_ok;
              phase_nxt        = PH_LEN_HI;
            end else begin
              phase_nxt = PH_CLASS;
            end
          end else begin
            phase_nxt = PH_SYMBOLS;
          end
        end
      end
      PH_SYMBOLS: begin
        bytes_nxt         = bytes_inc;
        res_valid         = 1'b1;
        res.has_entry     = 1'b1;
        res.table_num     = table_r;
        res.entry_index   = sidx_r;
        res.symbol        = seg_byte;
        res.code_length   = eff_len;
        res.code          = eff_code[15:0];
        res.code_overflow = (eff_len == 5'd0) || ((eff_code >> eff_len) != '0);
        len_nxt   = eff_len;
        left_nxt  = (eff_left != 8'd0) ? (eff_left - 8'd1) : 8'd0;
        code_nxt  = (eff_code == CODE_SAT) ? CODE_SAT : (eff_code + 17'd1);
        sidx_nxt  = sidx_r + 12'd1;
        sleft_nxt = sleft_r - 12'd1;
        if (sleft_nxt == 12'd0) begin
          res.table_last = 1'b1;
          if (bnd_done) begin
            res.segment_done = 1'b1;
            res.segment_ok   = bnd_ok;
            phase_nxt        = PH_LEN_HI;
          end else begin
            phase_nxt = PH_CLASS;
          end
        end
      end
      default: begin
        seg_len_nxt = {seg_byte, 8'd0};
        phase_nxt   = PH_LEN_LO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN_HI;
      seg_len_r <= 16'd0;
      bytes_r   <= 17'd0;
      table_r   <= 3'd0;
      cpos_r    <= 4'd0;
      sum_r     <= 12'd0;
      len_r     <= 5'd0;
      left_r    <= 8'd0;
      code_r    <= '0;
      sidx_r    <= 12'd0;
      sleft_r   <= 12'd0;
    end else if (hs.accept) begin
      phase_r   <= phase_nxt;
      seg_len_r <= seg_len_nxt;
      bytes_r   <= bytes_nxt;
      table_r   <= table_nxt;
      cpos_r    <= cpos_nxt;
      sum_r     <= sum_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      code_r    <= code_nxt;
      sidx_r    <= sidx_nxt;
      sleft_r   <= sleft_nxt;
    end
  end

  // count store, read only after all sixteen counts of a table are in
  always_ff @(posedge clk) begin
    if (hs.accept && cnt_we) begin
      counts_r[cpos_r] <= seg_byte;
      nz_r[cpos_r]     <= |seg_byte;
    end
  end

endmodule

### rtl/core/jdht_out_reg.sv
// result register with valid/stall handshake toward the receiver
`timescale 1ns / 1ps

module jdht_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           res_valid,
  input  jdht_pkg::res_t res,
  output jdht_pkg::hs_t  hs,
  output logic           out_valid,
  input  logic           out_stall,
  output jdht_pkg::res_t out_res
);
  import jdht_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  // the register is free when empty or being taken this cycle
  assign in_stall  = out_valid_r && out_stall;
  assign hs.accept = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (hs.accept) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hs.accept && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

### rtl/core/jpeg_dht_canonical_huffman.sv
// jpeg dht segment parser with canonical huffman code generation
// Input channel: in_valid/in_stall carry one segment byte per item, starting
//   with the two length bytes (high first), then per table a class/id byte,
//   sixteen length counts and the symbol bytes.
// Output channel: out_valid/out_stall carry result items. Each symbol byte
//   gives one entry with table, index, symbol, code length and code. A
//   segment end that falls on an empty table or right after the length word
//   gives an item with only segment_done/segment_ok; other bytes give none.
// Output register: a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_stall is low. Each byte goes through
//   a single pass of logic; the longest part is the skip over empty code
//   lengths, a 16-bit priority search plus a saturating 17-bit shift.
// Stall: while a result is held and out_stall is high, in_stall is high and
//   no byte is taken; when the held result is taken the next byte may enter
//   in the same cycle.
// Reset (rst_n low, synchronous): the output register empties and the block
//   waits for the length high byte of a new segment. After a segment ends it
//   again waits for a length word.
`timescale 1ns / 1ps

module jpeg_dht_canonical_huffman (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_seg_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_entry,
  output logic [2:0]  out_table_num,
  output logic [11:0] out_entry_index,
  output logic [7:0]  out_symbol,
  output logic [4:0]  out_code_length,
  output logic [15:0] out_code,
  output logic        out_code_overflow,
  output logic        out_table_last,
  output logic        out_segment_done,
  output logic        out_segment_ok
);
  import jdht_pkg::*;

  hs_t  hs;
  logic res_valid;
  res_t res;
  res_t out_res;

  jdht_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .hs        (hs),
    .seg_byte  (in_seg_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  jdht_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res       (res),
    .hs        (hs),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_has_entry     = out_res.has_entry;
  assign out_table_num     = out_res.table_num;
  assign out_entry_index   = out_res.entry_index;
  assign out_symbol        = out_res.symbol;
  assign out_code_length   = out_res.code_length;
  assign out_code          = out_res.code;
  assign out_code_overflow = out_res.code_overflow;
  assign out_table_last    = out_res.table_last;
  assign out_segment_done  = out_res.segment_done;
  assign out_segment_ok    = out_res.segment_ok;

endmodule

### rtl/core/jdht_checker.sv
// port-level checks for the dht parser, bound to the top level
`timescale 1ns / 1ps
`include "jpeg_dht_canonical_huffman_macros.svh"

module jdht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_has_entry,
  input logic [11:0] out_entry_index,
  input logic [7:0]  out_symbol,
  input logic [15:0] out_code,
  input logic        out_table_last,
  input logic        out_segment_done,
  input logic        out_segment_ok
);

  `JDHT_ASSERT_IMP(a_bare_item_ends_segment,
    out_valid && !out_has_entry, out_segment_done,
    "item without entry does not end the segment")
  `JDHT_ASSERT_IMP(a_ok_needs_done,
    out_valid && out_segment_ok, out_segment_done,
    "segment ok without segment done")
  `JDHT_ASSERT_IMP(a_end_entry_is_last,
    out_valid && out_has_entry && out_segment_done, out_table_last,
    "segment ends inside a table")
  `JDHT_ASSERT_IMP(a_stall_only_when_full,
    in_stall, out_valid && out_stall,
    "input stalled while result register free")
  `JDHT_ASSERT_NXT(a_held_result,
    out_valid && out_stall,
    out_valid && $stable(out_code) && $stable(out_symbol) && $stable(out_entry_index),
    "stalled result changed")

endmodule

bind jpeg_dht_canonical_huffman jdht_checker u_jdht_checker (.*);

### test/jpeg_dht_canonical_huffman_tb.sv
// testbench for the dht segment parser: table-driven and random segments checked
// against a behavioral code generator
`timescale 1ns / 1ps

module jpeg_dht_canonical_huffman_tb;
  import jdht_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_seg_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_has_entry;
  logic [2:0]  out_table_num;
  logic [11:0] out_entry_index;
  logic [7:0]  out_symbol;
  logic [4:0]  out_code_length;
  logic [15:0] out_code;
  logic        out_code_overflow;
  logic        out_table_last;
  logic        out_segment_done;
  logic        out_segment_ok;

  jpeg_dht_canonical_huffman DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_seg_byte(in_seg_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_has_entry(out_has_entry), .out_table_num(out_table_num),
    .out_entry_index(out_entry_index), .out_symbol(out_symbol),
    .out_code_length(out_code_length), .out_code(out_code),
    .out_code_overflow(out_code_overflow), .out_table_last(out_table_last),
    .out_segment_done(out_segment_done), .out_segment_ok(out_segment_ok)
  );

  typedef struct {
    logic [7:0] b;
    bit         typed;
    bit         has_res;
    res_t       r;
  } dir_row_t;

  // behavioral parser state
  phase_t      ph;
  logic [15:0] seg_len;
  logic [16:0] consumed;
  logic [2:0]  tbl;
  logic [3:0]  cnt_pos;
  logic [7:0]  len_counts [NUM_LENGTHS];
  logic [4:0]  cur_len;
  logic [7:0]  left_len;
  logic [16:0] code_nx;
  logic [11:0] sym_idx;
  logic [11:0] sym_left;

  res_t     due_results[$];
  dir_row_t dir_rows[$];
  int       mismatch_count = 0;
  int       sent_items = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [16:0] sat_code(input logic [17:0] v);
    return (v > {1'b0, CODE_SAT}) ? CODE_SAT : v[16:0];
  endfunction

  // segment end check at a table boundary; returns 1 when the segment ends
  function automatic bit seg_boundary(inout res_t r);
    bit          ended;
    bit          ok;
    logic [16:0] target;
    target = {1'b0, seg_len} - 17'd2;
    if (seg_len < MIN_SEG_LEN) begin
      ended = 1'b1;
      ok = 1'b0;
    end else begin
      ended = consumed >= target;
      ok = consumed == target;
    end
    if (!ended) begin
      ph = PH_CLASS;
      return 1'b0;
    end
    r.segment_done = 1'b1;
    r.segment_ok = ok;
    ph = PH_LEN_HI;
    return 1'b1;
  endfunction

  function automatic void dht_predict(input logic [7:0] b, output bit produced,
                                      output res_t r);
    int sum;
    r = '0;
    produced = 1'b0;
    case (ph)
      PH_LEN_LO: begin
        seg_len = {seg_len[15:8], b};
        consumed = '0;
        produced = seg_boundary(r);
      end
      PH_CLASS: begin
        consumed = consumed + 17'd1;
        tbl = {b[4], b[1:0]};
        cnt_pos = '0;
        ph = PH_COUNTS;
      end
      PH_COUNTS: begin
        consumed = consumed + 17'd1;
        len_counts[cnt_pos] = b;
        if (cnt_pos != LAST_COUNT) begin
          cnt_pos = cnt_pos + 4'd1;
        end else begin
          sum = 0;
          for (int k = 0; k < NUM_LENGTHS; k++) sum += len_counts[k];
          sym_left = sum[11:0];
          sym_idx = '0;
          code_nx = '0;
          cur_len = '0;
          left_len = '0;
          if (sym_left == 0) produced = seg_boundary(r);
          else ph = PH_SYMBOLS;
        end
      end
      PH_SYMBOLS: begin
        consumed = consumed + 17'd1;
        // skip over lengths with no codes left, doubling the code each step
        while (left_len == 0 && cur_len < MAX_LEN) begin
          code_nx = sat_code({1'b0, code_nx} << 1);
          cur_len = cur_len + 5'd1;
          left_len = len_counts[cur_len - 5'd1];
        end
        r.has_entry = 1'b1;
        r.table_num = tbl;
        r.entry_index = sym_idx;
        r.symbol = b;
        r.code_length = cur_len;
        r.code = code_nx[15:0];
        r.code_overflow = (cur_len == 0) || ({1'b0, code_nx} >= (18'd1 << cur_len));
        if (left_len > 0) left_len = left_len - 8'd1;
        code_nx = sat_code({1'b0, code_nx} + 18'd1);
        sym_idx = sym_idx + 12'd1;
        sym_left = sym_left - 12'd1;
        if (sym_left == 0) begin
          r.table_last = 1'b1;
          void'(seg_boundary(r));
        end
        produced = 1'b1;
      end
      default: begin
        seg_len = {b, 8'h00};
        ph = PH_LEN_LO;
      end
    endcase
  endfunction

  function automatic res_t mk_end(input bit ok);
    res_t r;
    r = '0;
    r.segment_done = 1'b1;
    r.segment_ok = ok;
    return r;
  endfunction

  function automatic res_t mk_entry(input logic [2:0] tn, input logic [11:0] idx,
                                    input logic [7:0] sym, input logic [4:0] len,
                                    input logic [15:0] code, input bit ovf,
                                    input bit last, input bit ended, input bit ok);
    res_t r;
    r = '{has_entry: 1'b1, table_num: tn, entry_index: idx, symbol: sym,
          code_length: len, code: code, code_overflow: ovf, table_last: last,
          segment_done: ended, segment_ok: ok};
    return r;
  endfunction

  function automatic string res_str(input res_t r);
    return $sformatf("entry=%0b tbl=%0d idx=%0d sym=%02h len=%0d code=%04h ovf=%0b last=%0b done=%0b ok=%0b",
                     r.has_entry, r.table_num, r.entry_index, r.symbol, r.code_length,
                     r.code, r.code_overflow, r.table_last, r.segment_done, r.segment_ok);
  endfunction

  function automatic void note_fail(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed, input bit has_res,
                                  input res_t r);
    dir_row_t row;
    row.b = b;
    row.typed = typed;
    row.has_res = has_res;
    row.r = r;
    dir_rows.push_back(row);
  endfunction

  // drives one byte, waits for it to be taken and predicts its result
  task automatic send_byte(input logic [7:0] b, output bit produced, output res_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seg_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    dht_predict(b, produced, r);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    bit   produced;
    res_t r;
    send_byte(b, produced, r);
    if (produced) due_results.push_back(r);
  endtask

  task automatic send_segment(input int seg_no);
    logic [7:0] body[$];
    logic [7:0] cnt [NUM_LENGTHS];
    int         kind;
    int         ntab;
    int         fl;
    int         total;
    int         len_decl;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // length word alone: below two or exactly two
      feed_byte(8'h00);
      feed_byte(8'($urandom_range(0, 2)));
    end else begin
      ntab = $urandom_range(1, 3);
      for (int t = 0; t < ntab; t++) begin
        body.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < NUM_LENGTHS; k++) cnt[k] = 8'h00;
        fl = $urandom_range(0, 99);
        if (seg_no % 25 == 7 && t == 0) begin
          cnt[$urandom_range(0, 15)] = 8'hFF;
        end else if (fl < 15) begin
          // empty table
        end else if (fl < 30) begin
          // too many short codes: later codes overflow, some saturate
          cnt[0] = 8'($urandom_range(3, 8));
          repeat ($urandom_range(1, 3)) cnt[$urandom_range(1, 15)] += 8'd1;
        end else begin
          repeat ($urandom_range(1, 12)) cnt[$urandom_range(0, 15)] += 8'd1;
        end
        total = 0;
        for (int k = 0; k < NUM_LENGTHS; k++) begin
          body.push_back(cnt[k]);
          total += cnt[k];
        end
        repeat (total) body.push_back(8'($urandom_range(0, 255)));
      end
      len_decl = 2 + body.size();
      if (kind < 16) begin
        len_decl += ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 4);
      end else if (kind < 22) begin
        // segment cut short; the next bytes get parsed as its remainder
        repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
      end
      feed_byte(len_decl[15:8]);
      feed_byte(len_decl[7:0]);
      foreach (body[i]) feed_byte(body[i]);
    end
    // bring the parser back to a segment start
    while (ph != PH_LEN_HI) begin
      if (ph == PH_COUNTS) feed_byte(8'h00);
      else feed_byte(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_has_entry, out_table_num, out_entry_index, out_symbol, out_code_length,
             out_code, out_code_overflow, out_table_last, out_segment_done, out_segment_ok};
      if (due_results.size() == 0) begin
        note_fail($sformatf("unexpected result: %s", res_str(got)));
      end else begin
        want = due_results.pop_front();
        if (got !== want)
          note_fail($sformatf("mismatch\n  expected %s\n  actual   %s",
                              res_str(want), res_str(got)));
      end
    end
  end

  initial begin
    bit   produced;
    res_t r;
    ph = PH_LEN_HI;
    seg_len = '0;
    consumed = '0;
    tbl = '0;
    cnt_pos = '0;
    cur_len = '0;
    left_len = '0;
    code_nx = '0;
    sym_idx = '0;
    sym_left = '0;
    for (int k = 0; k < NUM_LENGTHS; k++) len_counts[k] = 8'h00;

    // length below two ends right after the length word, not ok
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h01, 1'b1, 1'b1, mk_end(1'b0));
    // length of two: empty segment, ok
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h02, 1'b1, 1'b1, mk_end(1'b1));
    // length 20 covers 18 table bytes, the table runs two past the end
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h14, 1'b1, 1'b0, '0);
    add_row(8'h11, 1'b1, 1'b0, '0);
    add_row(8'h03, 1'b0, 1'b0, '0);
    repeat (15) add_row(8'h00, 1'b0, 1'b0, '0);
    // three one-bit codes: the third does not fit
    add_row(8'h00, 1'b1, 1'b1, mk_entry(3'd5, 12'd0, 8'h00, 5'd1, 16'd0, 0, 0, 0, 0));
    add_row(8'h80, 1'b1, 1'b1, mk_entry(3'd5, 12'd1, 8'h80, 5'd1, 16'd1, 0, 0, 0, 0));
    add_row(8'hFF, 1'b1, 1'b1, mk_entry(3'd5, 12'd2, 8'hFF, 5'd1, 16'd2, 1, 1, 1, 0));

    tx_idle_pct = 14;
    rx_idle_pct = 58;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, produced, r);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].has_res) due_results.push_back(dir_rows[i].r);
      end else if (produced) begin
        due_results.push_back(r);
      end
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (sent_items < 26 + (p + 1) * 508) send_segment(sent_items / 40);
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
